### rtl/core/iasu_pkg.sv
// shared types and opcode/trap codes for the integer add/subtract unit
`timescale 1ns / 1ps
`default_nettype none

package iasu_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned OpW   = 5;
	localparam int unsigned TrapW = 2;

	typedef enum logic [OpW-1:0] {
		OP_ADD    = 5'd0,
		OP_ADDI   = 5'd1,
		OP_ADDK   = 5'd2,
		OP_ADDKC  = 5'd3,
		OP_ADDIK  = 5'd4,
		OP_ADDIKC = 5'd5,
		OP_SUB    = 5'd6,
		OP_CMP    = 5'd7,
		OP_CMPU   = 5'd8,
		OP_RSUB   = 5'd9,
		OP_RSUBI  = 5'd10,
		OP_MADDI  = 5'd11,
		OP_MADDIU = 5'd12,
		OP_MADDU  = 5'd13,
		OP_SLT    = 5'd14,
		OP_SLTI   = 5'd15,
		OP_SLTU   = 5'd16,
		OP_SLTIU  = 5'd17,
		OP_SUBU   = 5'd18,
		OP_NEGU   = 5'd19,
		OP_TEQ    = 5'd20
	} op_t;

	typedef enum logic [TrapW-1:0] {
		TRAP_NONE = 2'd0,
		TRAP_OVF  = 2'd1,
		TRAP_TEQ  = 2'd2
	} trap_t;

	// one instruction as held in the input stage
	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [DataW-1:0] imm;
	} item_t;

	// what the execute logic hands to the output register
	typedef struct packed {
		logic [DataW-1:0] result;
		logic             we;
		trap_t            trap;
		logic             carry_upd;
		logic             carry_out;
	} exec_res_t;

endpackage

`default_nettype wire

### rtl/core/iasu_in_stage.sv
// input register stage of the integer add/subtract unit
`timescale 1ns / 1ps
`default_nettype none

module iasu_in_stage import iasu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire item_t in_item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

### rtl/core/iasu_exec.sv
// combinational add/subtract/compare logic for one instruction
`timescale 1ns / 1ps
`default_nettype none

module iasu_exec import iasu_pkg::*; (
	input  wire item_t     item,
	input  wire logic      carry_in,
	output exec_res_t      res
);

	logic [DataW-1:0] sext_imm;
	logic [DataW-1:0] a_plus_b;
	logic [DataW-1:0] a_minus_b;
	logic [DataW-1:0] b_minus_a;
	logic [DataW-1:0] a_plus_imm;
	logic [DataW-1:0] a_plus_sext;
	logic [DataW-1:0] k_operand;
	logic             k_cin;
	logic [DataW:0]   k_sum;
	op_t              opc;

	assign opc         = op_t'(item.op);
	assign sext_imm    = {{(DataW-16){item.imm[15]}}, item.imm[15:0]};
	assign a_plus_b    = item.a + item.b;
	assign a_minus_b   = item.a - item.b;
	assign b_minus_a   = item.b - item.a;
	assign a_plus_imm  = item.a + item.imm;
	assign a_plus_sext = item.a + sext_imm;

	// carry-keeping adds share one 33-bit adder
	assign k_operand = (opc == OP_ADDK || opc == OP_ADDKC) ? item.b : item.imm;
	assign k_cin     = (opc == OP_ADDKC || opc == OP_ADDIKC) ? carry_in : 1'b0;
	assign k_sum     = {1'b0, item.a} + {1'b0, k_operand} + {{DataW{1'b0}}, k_cin};

	always_comb begin
		res.result    = '0;
		res.we        = 1'b1;
		res.trap      = TRAP_NONE;
		res.carry_upd = 1'b0;
		res.carry_out = k_sum[DataW];
		case (opc)
			OP_ADD, OP_MADDU: res.result = a_plus_b;
			OP_ADDI:          res.result = a_plus_imm;
			OP_ADDK, OP_ADDKC, OP_ADDIK, OP_ADDIKC: begin
				res.result    = k_sum[DataW-1:0];
				res.carry_upd = 1'b1;
			end
			OP_SUB, OP_SUBU:  res.result = a_minus_b;
			OP_CMP, OP_RSUB:  res.result = b_minus_a;
			OP_CMPU: begin
				res.result          = b_minus_a;
				res.result[DataW-1] = item.a > item.b;
			end
			OP_RSUBI:         res.result = item.imm - item.a;
			OP_MADDI: begin
				res.result = a_plus_sext;
				// same operand signs, different sum sign
				if (item.a[DataW-1] == sext_imm[DataW-1] &&
				    a_plus_sext[DataW-1] != item.a[DataW-1]) begin
					res.trap = TRAP_OVF;
					res.we   = 1'b0;
				end
			end
			OP_MADDIU:        res.result = a_plus_sext;
			OP_SLT:   res.result = {{(DataW-1){1'b0}}, $signed(item.a) < $signed(item.b)};
			OP_SLTI:  res.result = {{(DataW-1){1'b0}}, $signed(item.a) < $signed(item.imm)};
			OP_SLTU:  res.result = {{(DataW-1){1'b0}}, item.a < item.b};
			OP_SLTIU: res.result = {{(DataW-1){1'b0}}, item.a < item.imm};
			OP_NEGU:          res.result = '0 - item.a;
			OP_TEQ: begin
				res.we   = 1'b0;
				res.trap = (item.a == item.b) ? TRAP_TEQ : TRAP_NONE;
			end
			default: begin
				res.we = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/integer_add_sub_unit_top.sv
// top level of the integer add/subtract unit with kept carry flag
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_stall, op, operand_a, operand_b,   | into unit
//          | immediate                                       |
//  out     | out_valid, out_stall, result, write_enable,     | out of unit
//          | trap, carry_flag                                |
//
// a result is held in the input register and then in the output register before
// its result transaction can be taken
// one transaction per cycle sustained while out_stall stays low, set by the input and output registers
// reset clears both stage valid bits and the carry flag
// the carry flag advances when an instruction moves into the output register,
// so it follows instruction order exactly
// a stalled output holds its result; the input stage still takes one more
// transaction, then in_stall rises until the output drains
`timescale 1ns / 1ps
`default_nettype none

module integer_add_sub_unit_top import iasu_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [OpW-1:0]     op,
	input  wire logic [DataW-1:0]   operand_a,
	input  wire logic [DataW-1:0]   operand_b,
	input  wire logic signed [DataW-1:0] immediate,
	// output channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [DataW-1:0]        result,
	output logic                    write_enable,
	output logic [TrapW-1:0]        trap,
	output logic                    carry_flag
);

	item_t     in_item;
	item_t     item_s1;
	logic      valid_s1;
	logic      out_free;
	logic      advance;
	logic      carry_q;
	exec_res_t exec_res;

	logic [DataW-1:0] result_q;
	logic             we_q;
	trap_t            trap_q;
	logic             carry_flag_q;
	logic             out_valid_q;

	assign in_item = '{op: op, a: operand_a, b: operand_b, imm: immediate};

	// output register can take a new result when empty or being drained
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;

	iasu_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	iasu_exec u_exec (
		.item     (item_s1),
		.carry_in (carry_q),
		.res      (exec_res)
	);

	// carry flag: only the carry-keeping adds change it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= 1'b0;
		end else if (advance && exec_res.carry_upd) begin
			carry_q <= exec_res.carry_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// result payload; flag shown is the value after this instruction
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q     <= exec_res.result;
			we_q         <= exec_res.we;
			trap_q       <= exec_res.trap;
			carry_flag_q <= exec_res.carry_upd ? exec_res.carry_out : carry_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result       = result_q;
	assign write_enable = we_q;
	assign trap         = trap_q;
	assign carry_flag   = carry_flag_q;

endmodule

`default_nettype wire

### dv/tb_integer_add_sub_unit_top.sv
// self-checking testbench for the integer add/subtract unit with kept carry flag
`timescale 1ns / 1ps

module tb_integer_add_sub_unit_top;
	import iasu_pkg::*;

	// first and last opcode with no operation behind it
	localparam logic [OpW-1:0] OP_UNDEF_FIRST = 5'd21;
	localparam logic [OpW-1:0] OP_UNDEF_LAST  = 5'd31;

	// one expected or observed result transaction, tagged with its opcode for messages
	typedef struct packed {
		logic [OpW-1:0]   op_sent;
		logic [DataW-1:0] result;
		logic             write_enable;
		logic [TrapW-1:0] trap;
		logic             carry_flag;
	} alu_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [OpW-1:0]     op = '0;
	logic [DataW-1:0]   operand_a = '0;
	logic [DataW-1:0]   operand_b = '0;
	logic [DataW-1:0]   immediate = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [DataW-1:0]   result;
	logic               write_enable;
	logic [TrapW-1:0]   trap;
	logic               carry_flag;

	integer_add_sub_unit_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.immediate    (immediate),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result       (result),
		.write_enable (write_enable),
		.trap         (trap),
		.carry_flag   (carry_flag)
	);

	always #2 clk = ~clk;

	// expected results in instruction order, and the carry flag as the unit should hold it
	alu_out_t    pending_results[$];
	logic        model_carry = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned stall_hold = 0;
	int unsigned stall_mode = 0;
	int unsigned stall_phase = 0;

	// expected outcome of one instruction; advances model_carry for the carry-keeping adds
	function automatic alu_out_t predict_alu(input logic [OpW-1:0] opc,
			input logic [DataW-1:0] a, input logic [DataW-1:0] b,
			input logic [DataW-1:0] imm);
		alu_out_t         r;
		logic [DataW:0]   wide;
		logic [DataW-1:0] ext;
		r.op_sent = opc;
		r.result = '0;
		r.write_enable = 1'b1;
		r.trap = TRAP_NONE;
		ext = {{16{imm[15]}}, imm[15:0]};
		case (opc)
			OP_ADD, OP_MADDU: r.result = a + b;
			OP_ADDI: r.result = a + imm;
			OP_ADDK, OP_ADDKC: begin
				wide = {1'b0, a} + {1'b0, b}
					+ {{DataW{1'b0}}, ((opc == OP_ADDKC) ? model_carry : 1'b0)};
				r.result = wide[DataW-1:0];
				model_carry = wide[DataW];
			end
			OP_ADDIK, OP_ADDIKC: begin
				wide = {1'b0, a} + {1'b0, imm}
					+ {{DataW{1'b0}}, ((opc == OP_ADDIKC) ? model_carry : 1'b0)};
				r.result = wide[DataW-1:0];
				model_carry = wide[DataW];
			end
			OP_SUB, OP_SUBU: r.result = a - b;
			OP_CMP, OP_RSUB: r.result = b - a;
			OP_CMPU: begin
				r.result = b - a;
				r.result[DataW-1] = (a > b);
			end
			OP_RSUBI: r.result = imm - a;
			OP_MADDI: begin
				r.result = a + ext;
				// same-sign operands with a sign flip in the sum
				if (a[DataW-1] == ext[DataW-1] && r.result[DataW-1] != a[DataW-1]) begin
					r.trap = TRAP_OVF;
					r.write_enable = 1'b0;
				end
			end
			OP_MADDIU: r.result = a + ext;
			OP_SLT: r.result = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
			OP_SLTI: r.result = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
			OP_SLTU: r.result = (a < b) ? 32'd1 : 32'd0;
			OP_SLTIU: r.result = (a < imm) ? 32'd1 : 32'd0;
			OP_NEGU: r.result = 32'd0 - a;
			OP_TEQ: begin
				r.write_enable = 1'b0;
				r.trap = (a == b) ? TRAP_TEQ : TRAP_NONE;
			end
			default: r.write_enable = 1'b0;
		endcase
		r.carry_flag = model_carry;
		return r;
	endfunction

	// operand values weighted toward the sign and wrap boundaries
	function automatic logic [DataW-1:0] pick_word();
		logic [DataW-1:0] w;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 5))
					0: w = 32'h0000_0000;
					1: w = 32'h0000_0001;
					2: w = 32'h7fff_ffff;
					3: w = 32'h8000_0000;
					4: w = 32'hffff_ffff;
					default: w = 32'hffff_fffe;
				endcase
			end
			1: w = $urandom_range(0, 255);
			2: w = 32'd0 - $urandom_range(1, 256);
			3: w = {16'($urandom_range(0, 65535)), ($urandom_range(0, 1) ? 16'h7fff : 16'h8000)};
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// one input transaction; the sender runs in bursts with random gaps between them
	task automatic send_instr(input logic [OpW-1:0] opc, input logic [DataW-1:0] a,
			input logic [DataW-1:0] b, input logic [DataW-1:0] imm);
		if (burst_left == 0) begin
			// idle gap with junk on the payload
			in_valid <= 1'b0;
			op <= OpW'($urandom());
			operand_a <= $urandom();
			operand_b <= $urandom();
			immediate <= $urandom();
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= opc;
		operand_a <= a;
		operand_b <= b;
		immediate <= imm;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(predict_alu(opc, a, b, imm));
	endtask

	task automatic check_field(input string name, input alu_out_t want,
			input logic [DataW-1:0] exp_val, input logic [DataW-1:0] act_val);
		if (exp_val !== act_val) begin
			$display("%0t: op %0d %s expected %h actual %h", $time, want.op_sent, name,
				exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// result side: check each accepted transaction, then pick the next stall value
	always @(posedge clk) begin : result_monitor
		alu_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transaction expected none actual %h %b %h %b",
					$time, result, write_enable, trap, carry_flag);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("result", want, want.result, result);
				check_field("write_enable", want, DataW'(want.write_enable),
					DataW'(write_enable));
				check_field("trap", want, DataW'(want.trap), DataW'(trap));
				check_field("carry_flag", want, DataW'(want.carry_flag), DataW'(carry_flag));
			end
		end
		// stall pattern: free-running, light, heavy or periodic stretches
		if (stall_hold == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_hold = $urandom_range(20, 200);
		end
		stall_hold--;
		stall_phase++;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_phase % 3 == 0);
		endcase
	end

	// corner values for every opcode, overflow and teq cases, undefined opcodes
	task automatic test_directed_corners();
		send_instr(OP_ADDK, 32'hffff_ffff, 32'h0000_0001, 32'h0);
		send_instr(OP_ADDKC, 32'h0, 32'h0, 32'h0);
		send_instr(OP_ADDIK, 32'hffff_ffff, 32'h0, 32'hffff_ffff);
		send_instr(OP_ADDIKC, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
		send_instr(OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0);
		send_instr(OP_ADDI, 32'hffff_ffff, 32'h0, 32'h7fff_ffff);
		send_instr(OP_SUB, 32'h0, 32'hffff_ffff, 32'h0);
		send_instr(OP_CMP, 32'h1, 32'h0, 32'h0);
		send_instr(OP_CMPU, 32'hffff_ffff, 32'h0, 32'h0);
		send_instr(OP_RSUB, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		send_instr(OP_RSUBI, 32'h1, 32'h0, 32'h8000_0000);
		// addi positive and negative overflow, then high immediate bits ignored
		send_instr(OP_MADDI, 32'h7fff_ffff, 32'h0, 32'h0000_0001);
		send_instr(OP_MADDI, 32'h8000_0000, 32'h0, 32'h0000_ffff);
		send_instr(OP_MADDI, 32'h0000_0005, 32'h0, 32'h1234_8000);
		send_instr(OP_MADDIU, 32'h7fff_ffff, 32'h0, 32'h0000_0001);
		send_instr(OP_MADDU, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
		send_instr(OP_SLT, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
		send_instr(OP_SLTI, 32'h0, 32'h0, 32'h8000_0000);
		send_instr(OP_SLTU, 32'h0, 32'hffff_ffff, 32'h0);
		send_instr(OP_SLTIU, 32'h7fff_ffff, 32'h0, 32'h8000_0000);
		send_instr(OP_SUBU, 32'h0, 32'h1, 32'h0);
		send_instr(OP_NEGU, 32'h8000_0000, 32'h0, 32'h0);
		send_instr(OP_TEQ, 32'hffff_ffff, 32'hffff_ffff, 32'h0);
		send_instr(OP_TEQ, 32'h0, 32'h1, 32'h0);
		send_instr(OP_UNDEF_FIRST, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_instr(OP_UNDEF_LAST, 32'h1, 32'h1, 32'h1);
	endtask

	// random opcodes over the whole field, some with equal operands
	task automatic test_random_mix(input int unsigned count);
		logic [OpW-1:0]   opc;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		repeat (count) begin
			opc = ($urandom_range(0, 9) == 0)
				? OpW'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST))
				: OpW'($urandom_range(0, 20));
			a = pick_word();
			b = ($urandom_range(0, 7) == 0) ? a : pick_word();
			send_instr(opc, a, b, pick_word());
		end
	endtask

	// carry-keeping add chains with near-wrap operands; other ops in between must leave carry alone
	task automatic test_carry_chains(input int unsigned chains);
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [OpW-1:0]   opc;
		repeat (chains) begin
			a = pick_word();
			b = ~a + $urandom_range(0, 3);
			send_instr($urandom_range(0, 1) ? OP_ADDK : OP_ADDIK, a, b, b);
			repeat ($urandom_range(1, 8)) begin
				a = pick_word();
				b = ~a + $urandom_range(0, 2) - 1;
				case ($urandom_range(0, 9))
					0: opc = OpW'($urandom_range(0, 31));
					1, 2, 3, 4: opc = OP_ADDKC;
					default: opc = OP_ADDIKC;
				endcase
				send_instr(opc, a, b, ($urandom_range(0, 3) == 0) ? pick_word() : b);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_random_mix(1500);
		test_carry_chains(100);
		in_valid <= 1'b0;
		// drain, then keep running to catch any extra result
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/iasu_pkg.sv
rtl/core/iasu_in_stage.sv
rtl/core/iasu_exec.sv
rtl/core/integer_add_sub_unit_top.sv
dv/tb_integer_add_sub_unit_top.sv
